@@ rtl/bjse_pkg.sv @@
// Package for the bounded JSON string escaper: word types, queue entry type,
// escape classification and expansion helpers. No dependencies.
package bjse_pkg;

  // Default budget counter width and configuration defaults
  localparam int unsigned SPACE_BITS_DEF = 16;
  localparam int unsigned CAP_BITS       = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd4096;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned PADDR_BITS     = 3;

  // Register map (register index taken from paddr[2])
  localparam logic REG_OUTPUT_CAPACITY = 1'b0;

  // Characters used by the expansion
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] HEX_DIGIT [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Expansion lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_PASS = 3'd1;
  localparam logic [2:0] LEN_PAIR = 3'd2;
  localparam logic [2:0] LEN_UNI  = 3'd6;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,   // nothing emitted for this byte
    ESC_PASS = 2'd1,   // byte passes unchanged
    ESC_PAIR = 2'd2,   // backslash plus one character
    ESC_UNI  = 2'd3    // backslash u 0 0 h h
  } esc_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic       was_truncated;
  } out_word_t;

  // One classified input byte, front to back
  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] data_byte;
    logic       last;
    logic       trunc;
  } esc_entry_t;

  function automatic logic [2:0] esc_len(input esc_kind_t kind);
    logic [2:0] len;
    case (kind)
      ESC_PASS: len = LEN_PASS;
      ESC_PAIR: len = LEN_PAIR;
      ESC_UNI:  len = LEN_UNI;
      default:  len = LEN_NONE;
    endcase
    return len;
  endfunction

  // Byte number idx of the expansion of c
  function automatic logic [7:0] esc_byte(input esc_kind_t kind, input logic [7:0] c,
                                          input logic [2:0] idx);
    logic [7:0] b;
    b = c;
    case (kind)
      ESC_PAIR: begin
        if (idx == 3'd0) b = CH_BSLASH;
        else if (c == CH_NL) b = CH_N;
        else if (c == CH_CR) b = CH_R;
        else if (c == CH_TAB) b = CH_T;
        else b = c;
      end
      ESC_UNI: begin
        case (idx)
          3'd0:    b = CH_BSLASH;
          3'd1:    b = CH_U;
          3'd2:    b = CH_ZERO;
          3'd3:    b = CH_ZERO;
          3'd4:    b = HEX_DIGIT[c[7:4]];
          default: b = HEX_DIGIT[c[3:0]];
        endcase
      end
      default: b = c;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/bounded_json_string_escaper_unit.sv @@
// Bounded JSON string escaper, top level: config register, front, queue, back.
// An accepted input byte is written into the entry queue and then loaded into the output register.
// Throughput: one input word per cycle for plain bytes while the entry queue is not full;
// an escape expands into a 2-byte or 6-byte output sequence, absorbed by the 4-entry entry queue.
// Reset (rst_n, synchronous, active low) empties the queue and output register,
// closes any open string and sets output_capacity to 4096.
module bounded_json_string_escaper_unit #(
  parameter int unsigned SPACE_BITS = bjse_pkg::SPACE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bjse_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bjse_pkg::out_word_t               out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bjse_pkg::PADDR_BITS-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic [bjse_pkg::CAP_BITS-1:0] capacity_r;
  logic                          cfg_wr;
  logic                          q_full, q_push, q_pop, q_valid;
  bjse_pkg::esc_entry_t          q_in, q_head;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == bjse_pkg::REG_OUTPUT_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == bjse_pkg::REG_OUTPUT_CAPACITY) ?
                      {16'd0, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bjse_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= cfg_pwdata[bjse_pkg::CAP_BITS-1:0];
    end
  end

  bjse_front #(.SPACE_BITS(SPACE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .capacity   (capacity_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  bjse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bjse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Truncation is reported only with the closing word
  a_trunc_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.string_done |-> !out_data.was_truncated)
    else $error("was_truncated set without string_done");

  // A word without data is always a closing word and carries a zero byte
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.string_done && (out_data.out_byte == 8'd0))
    else $error("status-only word malformed");

  // Input is held off only when the entry queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_full && !q_push)
    else $error("input stalled with queue space left");

endmodule

@@ rtl/bjse_front.sv @@
// Front end: accepts input words, classifies each byte and keeps the per-string
// budget and flags. Depends on bjse_pkg.
module bjse_front #(
  parameter int unsigned SPACE_BITS = bjse_pkg::SPACE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bjse_pkg::in_word_t              in_data,
  input  logic [bjse_pkg::CAP_BITS-1:0]   capacity,
  input  logic                            q_full,
  output logic                            push,
  output bjse_pkg::esc_entry_t            push_entry
);

  logic [SPACE_BITS-1:0] space_r, space_nxt;
  logic                  trunc_r, trunc_nxt;
  logic                  ended_r, ended_nxt;
  logic                  in_str_r, in_str_nxt;
  logic [SPACE_BITS-1:0] cap_load;
  logic [SPACE_BITS-1:0] sp;
  logic [SPACE_BITS-1:0] len_ext;
  logic                  tr, en;
  logic [7:0]            c;
  bjse_pkg::esc_kind_t   kind;
  logic [2:0]            len;
  logic                  accept;

  // Capacity saturates when the budget counter is narrower than the register
  generate
    if (SPACE_BITS >= bjse_pkg::CAP_BITS) begin : g_wide
      assign cap_load = SPACE_BITS'(capacity);
    end else begin : g_narrow
      assign cap_load = (|capacity[bjse_pkg::CAP_BITS-1:SPACE_BITS]) ?
                        {SPACE_BITS{1'b1}} : capacity[SPACE_BITS-1:0];
    end
  endgenerate

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.data_byte;

  // Classify the byte
  always_comb begin
    if (c inside {bjse_pkg::CH_BSLASH, bjse_pkg::CH_QUOTE, bjse_pkg::CH_NL,
                  bjse_pkg::CH_CR, bjse_pkg::CH_TAB}) begin
      kind = bjse_pkg::ESC_PAIR;
    end else if (c < bjse_pkg::CTRL_LIMIT) begin
      kind = bjse_pkg::ESC_UNI;
    end else begin
      kind = bjse_pkg::ESC_PASS;
    end
    len = bjse_pkg::esc_len(kind);
  end

  assign len_ext = {{(SPACE_BITS-3){1'b0}}, len};

  // Budget check and state update
  always_comb begin
    sp  = in_str_r ? space_r : cap_load;
    tr  = in_str_r && trunc_r;
    en  = in_str_r && ended_r;
    space_nxt  = sp;
    trunc_nxt  = tr;
    ended_nxt  = en;
    push_entry.kind      = bjse_pkg::ESC_NONE;
    push_entry.data_byte = c;
    push_entry.last      = in_data.end_of_string;
    if (!en) begin
      if (c == 8'd0) begin
        ended_nxt = 1'b1;
      end else if (len_ext > sp) begin
        trunc_nxt = 1'b1;
        ended_nxt = 1'b1;
      end else begin
        space_nxt = sp - len_ext;
        push_entry.kind = kind;
      end
    end
    push_entry.trunc = trunc_nxt;
    in_str_nxt = !in_data.end_of_string;
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_str_r <= 1'b0;
      trunc_r  <= 1'b0;
      ended_r  <= 1'b0;
    end else if (accept) begin
      in_str_r <= in_str_nxt;
      trunc_r  <= trunc_nxt;
      ended_r  <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      space_r <= space_nxt;
    end
  end

endmodule

@@ rtl/bjse_queue.sv @@
// Short FIFO of classified entries between front and back.
// Depends on bjse_pkg.
module bjse_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bjse_pkg::esc_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output bjse_pkg::esc_entry_t head
);

  localparam int unsigned PW = $clog2(bjse_pkg::Q_DEPTH);
  localparam int unsigned CW = $clog2(bjse_pkg::Q_DEPTH + 1);

  bjse_pkg::esc_entry_t slot_r [bjse_pkg::Q_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == CW'(bjse_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/bjse_back.sv @@
// Back end: expands each queued entry into output words through an output register,
// one per cycle unless out_ready stalls; empty non-closing entries are dropped. Depends on bjse_pkg.
module bjse_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  bjse_pkg::esc_entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bjse_pkg::out_word_t  out_data
);

  logic                out_valid_r, out_valid_nxt;
  bjse_pkg::out_word_t out_r, out_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [2:0]          cnt;
  logic                none, skip, load, last_item;

  // Build the next output word from the head entry
  always_comb begin
    cnt       = bjse_pkg::esc_len(head.kind);
    none      = (head.kind == bjse_pkg::ESC_NONE);
    skip      = head_valid && none && !head.last;
    load      = head_valid && !skip && (!out_valid_r || out_ready);
    last_item = none || (idx_r == cnt - 3'd1);
    pop       = skip || (load && last_item);

    out_nxt.out_byte      = none ? 8'd0 : bjse_pkg::esc_byte(head.kind, head.data_byte, idx_r);
    out_nxt.has_byte      = !none;
    out_nxt.string_done   = last_item && head.last;
    out_nxt.was_truncated = last_item && head.last && head.trunc;

    idx_nxt = idx_r;
    if (load) idx_nxt = last_item ? 3'd0 : idx_r + 3'd1;

    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
